// ----- rtl/cbc_pkg.sv -----
package cbc_pkg;

    localparam int RAM_BANK_COUNT_DEFAULT = 4;
    localparam int RAM_BANK_BYTES    = 8192;
    localparam int ROM_BANK_BYTES    = 16384;
    localparam int BANK_OFFSET_W     = $clog2(RAM_BANK_BYTES);
    localparam int ROM_OFFSET_W      = $clog2(ROM_BANK_BYTES);
    localparam int ROM_BANK_W        = 7;
    localparam int ROM_ADDR_W        = ROM_BANK_W + ROM_OFFSET_W;

    localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;

    typedef enum logic [2:0] {
        ACT_ROM_READ   = 3'd0,
        ACT_CTRL_WRITE = 3'd1,
        ACT_RAM_READ   = 3'd2,
        ACT_RAM_WRITE  = 3'd3,
        ACT_BOOT_UNMAP = 3'd4
    } action_t;

    typedef enum logic [2:0] {
        SRC_OPEN  = 3'd0,
        SRC_BOOT  = 3'd1,
        SRC_ROM   = 3'd2,
        SRC_RAM   = 3'd3,
        SRC_WRITE = 3'd4
    } source_t;

    typedef enum logic [1:0] {
        REG_CART_KIND  = 2'd0,
        REG_ROM_SIZE   = 2'd1,
        REG_RAM_SIZE   = 2'd2,
        REG_BOOT_START = 2'd3
    } reg_index_t;

    localparam logic [1:0] RAM_SIZE_FOUR_BANKS = 2'd3;

    typedef struct packed {
        logic       cart_kind;
        logic [2:0] rom_size_code;
        logic [1:0] ram_size_code;
        logic       boot_start;
        logic       boot_load;
    } cfg_t;

    typedef struct packed {
        source_t                 src;
        logic [ROM_ADDR_W-1:0]   rom_address;
        logic                    ram_we;
        logic                    ram_re;
    } decode_t;

endpackage

// ----- rtl/cbc_cfg.sv -----
module cbc_cfg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output cbc_pkg::cfg_t       cfg
);

    logic       cart_kind_reg;
    logic [2:0] rom_size_code_reg;
    logic [1:0] ram_size_code_reg;
    logic       boot_start_reg;
    logic       wr_en;
    cbc_pkg::reg_index_t index;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign index  = cbc_pkg::reg_index_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cart_kind_reg     <= 1'b1;
            rom_size_code_reg <= 3'd0;
            ram_size_code_reg <= 2'd0;
            boot_start_reg    <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (index)
                cbc_pkg::REG_CART_KIND:  cart_kind_reg     <= pwdata[0];
                cbc_pkg::REG_ROM_SIZE:   rom_size_code_reg <= pwdata[2:0];
                cbc_pkg::REG_RAM_SIZE:   ram_size_code_reg <= pwdata[1:0];
                cbc_pkg::REG_BOOT_START: boot_start_reg    <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (index)
            cbc_pkg::REG_CART_KIND:  prdata = {31'd0, cart_kind_reg};
            cbc_pkg::REG_ROM_SIZE:   prdata = {29'd0, rom_size_code_reg};
            cbc_pkg::REG_RAM_SIZE:   prdata = {30'd0, ram_size_code_reg};
            cbc_pkg::REG_BOOT_START: prdata = {31'd0, boot_start_reg};
            default:                 prdata = 32'd0;
        endcase
    end

    // the strap write also reloads the live overlay flag
    always_comb
    begin
        cfg.cart_kind     = cart_kind_reg;
        cfg.rom_size_code = rom_size_code_reg;
        cfg.ram_size_code = ram_size_code_reg;
        cfg.boot_start    = pwdata[0];
        cfg.boot_load     = wr_en && (index == cbc_pkg::REG_BOOT_START);
    end

endmodule

// ----- rtl/cbc_mapper.sv -----
module cbc_mapper #(
    parameter int RAM_BANK_COUNT = cbc_pkg::RAM_BANK_COUNT_DEFAULT,
    parameter int RAM_ADDR_W = $clog2(RAM_BANK_COUNT * cbc_pkg::RAM_BANK_BYTES)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cbc_pkg::cfg_t         cfg,
    input  logic                  fire,
    input  cbc_pkg::action_t      action,
    input  logic [15:0]           bus_address,
    input  logic [7:0]            write_data,
    output cbc_pkg::decode_t      dec,
    output logic [RAM_ADDR_W-1:0] ram_index
);

    localparam logic [1:0] BANK_WRAP [4] = '{
        2'(0 % RAM_BANK_COUNT), 2'(1 % RAM_BANK_COUNT),
        2'(2 % RAM_BANK_COUNT), 2'(3 % RAM_BANK_COUNT)
    };

    logic [3:0] ram_enable_nibble_reg, ram_enable_nibble_next;
    logic [4:0] low_bank_reg, low_bank_next;
    logic [1:0] upper_bits_reg, upper_bits_next;
    logic       banking_mode_reg, banking_mode_next;
    logic       boot_overlay_reg, boot_overlay_next;

    logic [8:0]                    mask_wide;
    logic [cbc_pkg::ROM_BANK_W-1:0] bank_mask;
    logic [cbc_pkg::ROM_BANK_W-1:0] rom_bank;
    logic                          ram_hit;
    logic [1:0]                    ram_bank;

    assign mask_wide = (9'd2 << cfg.rom_size_code) - 9'd1;
    assign bank_mask = mask_wide[cbc_pkg::ROM_BANK_W-1:0];

    always_comb
    begin
        if (bus_address[14])
            rom_bank = {upper_bits_reg, low_bank_reg} & bank_mask;
        else if (banking_mode_reg)
            rom_bank = {upper_bits_reg, 5'd0} & bank_mask;
        else
            rom_bank = '0;
    end

    // external ram window 0xa000-0xbfff
    assign ram_hit = cfg.cart_kind && (bus_address[15:13] == 3'b101)
                     && (ram_enable_nibble_reg == cbc_pkg::RAM_ENABLE_KEY)
                     && cfg.ram_size_code[1];
    assign ram_bank = BANK_WRAP[(cfg.ram_size_code == cbc_pkg::RAM_SIZE_FOUR_BANKS
                                 && banking_mode_reg) ? upper_bits_reg : 2'd0];
    assign ram_index = RAM_ADDR_W'({ram_bank, bus_address[cbc_pkg::BANK_OFFSET_W-1:0]});

    always_comb
    begin
        dec.src                = cbc_pkg::SRC_OPEN;
        dec.rom_address        = '0;
        dec.ram_we             = 1'b0;
        dec.ram_re             = 1'b0;
        ram_enable_nibble_next = ram_enable_nibble_reg;
        low_bank_next          = low_bank_reg;
        upper_bits_next        = upper_bits_reg;
        banking_mode_next      = banking_mode_reg;
        boot_overlay_next      = boot_overlay_reg;
        unique case (action)
            cbc_pkg::ACT_ROM_READ:
            begin
                if (bus_address[15:8] == 8'd0 && boot_overlay_reg)
                begin
                    dec.src         = cbc_pkg::SRC_BOOT;
                    dec.rom_address = cbc_pkg::ROM_ADDR_W'(bus_address);
                end
                else if (!bus_address[15])
                begin
                    dec.src = cbc_pkg::SRC_ROM;
                    if (cfg.cart_kind)
                        dec.rom_address = {rom_bank,
                                           bus_address[cbc_pkg::ROM_OFFSET_W-1:0]};
                    else
                        dec.rom_address = cbc_pkg::ROM_ADDR_W'(bus_address);
                end
            end
            cbc_pkg::ACT_CTRL_WRITE:
            begin
                dec.src = cbc_pkg::SRC_WRITE;
                if (cfg.cart_kind && !bus_address[15])
                begin
                    unique case (bus_address[14:13])
                        2'd0: ram_enable_nibble_next = write_data[3:0];
                        2'd1: low_bank_next = (write_data[4:0] == 5'd0) ? 5'd1
                                                                        : write_data[4:0];
                        2'd2: upper_bits_next = write_data[1:0];
                        default: banking_mode_next = write_data[0];
                    endcase
                end
            end
            cbc_pkg::ACT_RAM_READ:
            begin
                if (ram_hit)
                begin
                    dec.src    = cbc_pkg::SRC_RAM;
                    dec.ram_re = 1'b1;
                end
            end
            cbc_pkg::ACT_RAM_WRITE:
            begin
                dec.src    = cbc_pkg::SRC_WRITE;
                dec.ram_we = ram_hit;
            end
            cbc_pkg::ACT_BOOT_UNMAP:
            begin
                dec.src = cbc_pkg::SRC_WRITE;
                if (write_data != 8'd0)
                    boot_overlay_next = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ram_enable_nibble_reg <= 4'd0;
            low_bank_reg          <= 5'd1;
            upper_bits_reg        <= 2'd0;
            banking_mode_reg      <= 1'b0;
            boot_overlay_reg      <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                ram_enable_nibble_reg <= ram_enable_nibble_next;
                low_bank_reg          <= low_bank_next;
                upper_bits_reg        <= upper_bits_next;
                banking_mode_reg      <= banking_mode_next;
            end
            if (cfg.boot_load)
                boot_overlay_reg <= cfg.boot_start;
            else if (fire)
                boot_overlay_reg <= boot_overlay_next;
        end
    end

endmodule

// ----- rtl/cbc_ram.sv -----
module cbc_ram #(
    parameter int RAM_BANK_COUNT = cbc_pkg::RAM_BANK_COUNT_DEFAULT,
    parameter int RAM_ADDR_W = $clog2(RAM_BANK_COUNT * cbc_pkg::RAM_BANK_BYTES)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  we,
    input  logic                  re,
    input  logic [RAM_ADDR_W-1:0] addr,
    input  logic [7:0]            wdata,
    output logic [7:0]            rdata,
    output logic                  clearing
);

    localparam int RAM_DEPTH = RAM_BANK_COUNT * cbc_pkg::RAM_BANK_BYTES;

    logic [7:0]            mem [RAM_DEPTH];
    logic [7:0]            rdata_reg;
    logic [RAM_ADDR_W-1:0] clear_addr_reg;
    logic                  clearing_reg;

    assign clearing = clearing_reg;
    assign rdata    = rdata_reg;

    // zero sweep after reset, one byte a cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_addr_reg <= '0;
            clearing_reg   <= 1'b1;
        end
        else if (clearing_reg)
        begin
            clear_addr_reg <= clear_addr_reg + 1'b1;
            if (clear_addr_reg == RAM_ADDR_W'(RAM_DEPTH - 1))
                clearing_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
            mem[clear_addr_reg] <= 8'd0;
        else if (we)
            mem[addr] <= wdata;
        if (re)
            rdata_reg <= mem[addr];
    end

endmodule

// ----- rtl/cartridge_bank_controller.sv -----
// Cartridge bank controller: one bus access per transfer, one transfer per cycle
// sustained while the receiver keeps out_ready high. A transfer lands in an input
// register, is decoded there against the bank registers and the ram port, and its
// result is written to the output register when that register is free, which
// raises out_valid; the cartridge ram has a single port with registered read data,
// which sets that second stage. After reset the ram is zeroed one byte a cycle,
// RAM_BANK_COUNT * 8192 bytes (32768 at the default), during which in_ready stays
// low; register writes on the apb port are taken throughout. Program the registers
// only while no transfer is in flight.
module cartridge_bank_controller #(
    parameter int RAM_BANK_COUNT = cbc_pkg::RAM_BANK_COUNT_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  action,
    input  logic [15:0] bus_address,
    input  logic [7:0]  write_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  source,
    output logic [20:0] rom_address,
    output logic [7:0]  read_data
);

    localparam int RAM_ADDR_W = $clog2(RAM_BANK_COUNT * cbc_pkg::RAM_BANK_BYTES);

    cbc_pkg::cfg_t    cfg;
    cbc_pkg::decode_t dec;

    logic                  s1_valid_reg;
    cbc_pkg::action_t      s1_action_reg;
    logic [15:0]           s1_addr_reg;
    logic [7:0]            s1_data_reg;
    logic                  out_valid_reg;
    cbc_pkg::source_t      src_reg;
    logic [20:0]           rom_addr_reg;

    logic                  s2_take;
    logic                  s1_fire;
    logic                  in_fire;
    logic                  clearing;
    logic [RAM_ADDR_W-1:0] ram_index;
    logic [7:0]            ram_rdata;

    assign s2_take  = !out_valid_reg || out_ready;
    assign s1_fire  = s1_valid_reg && s2_take;
    assign in_ready = (!s1_valid_reg || s2_take) && !clearing;
    assign in_fire  = in_valid && in_ready;

    cbc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cbc_mapper #(
        .RAM_BANK_COUNT (RAM_BANK_COUNT),
        .RAM_ADDR_W     (RAM_ADDR_W)
    ) u_mapper (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .fire        (s1_fire),
        .action      (s1_action_reg),
        .bus_address (s1_addr_reg),
        .write_data  (s1_data_reg),
        .dec         (dec),
        .ram_index   (ram_index)
    );

    cbc_ram #(
        .RAM_BANK_COUNT (RAM_BANK_COUNT),
        .RAM_ADDR_W     (RAM_ADDR_W)
    ) u_ram (
        .clk      (clk),
        .rst_n    (rst_n),
        .we       (s1_fire && dec.ram_we),
        .re       (s1_fire && dec.ram_re),
        .addr     (ram_index),
        .wdata    (s1_data_reg),
        .rdata    (ram_rdata),
        .clearing (clearing)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
                s1_valid_reg <= 1'b1;
            else if (s1_fire)
                s1_valid_reg <= 1'b0;
            if (s2_take)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_action_reg <= cbc_pkg::action_t'(action);
            s1_addr_reg   <= bus_address;
            s1_data_reg   <= write_data;
        end
        if (s1_fire)
        begin
            src_reg      <= dec.src;
            rom_addr_reg <= dec.rom_address;
        end
    end

    assign out_valid   = out_valid_reg;
    assign source      = src_reg;
    assign rom_address = rom_addr_reg;
    // ram data register only moves on a ram read, so it holds while stalled
    assign read_data   = (src_reg == cbc_pkg::SRC_RAM) ? ram_rdata : 8'hFF;

endmodule

// ----- dv/tb_top.sv -----
module tb_top;

    localparam int QUIET_LIMIT = 150000;
    localparam int RAM_BYTES   = cbc_pkg::RAM_BANK_COUNT_DEFAULT * cbc_pkg::RAM_BANK_BYTES;

    typedef struct {
        cbc_pkg::source_t src;
        logic [20:0]      rom_addr;
        logic [7:0]       rdata;
    } bank_answer_t;

    class cart_scoreboard;
        logic         cart_kind;
        logic [2:0]   rom_code;
        logic [1:0]   ram_code;
        logic [3:0]   ram_key;
        logic [4:0]   low_bank;
        logic [1:0]   upper_bits;
        logic         bank_mode;
        logic         boot_overlay;
        logic [7:0]   cart_ram [RAM_BYTES];
        bank_answer_t answers [$];
        int           errors;

        function new();
            cart_kind = 1'b1;
            rom_code = 3'd0;
            ram_code = 2'd0;
            ram_key = 4'd0;
            low_bank = 5'd1;
            upper_bits = 2'd0;
            bank_mode = 1'b0;
            boot_overlay = 1'b0;
            errors = 0;
            foreach (cart_ram[i])
                cart_ram[i] = 8'h00;
        endfunction

        function void set_reg(cbc_pkg::reg_index_t idx, logic [31:0] value);
            case (idx)
                cbc_pkg::REG_CART_KIND:  cart_kind = value[0];
                cbc_pkg::REG_ROM_SIZE:   rom_code = value[2:0];
                cbc_pkg::REG_RAM_SIZE:   ram_code = value[1:0];
                // strap write reloads the live overlay flag as well
                cbc_pkg::REG_BOOT_START: boot_overlay = value[0];
                default: ;
            endcase
        endfunction

        function bit ram_slot(logic [15:0] addr, output int idx);
            int bank;
            bank = 0;
            idx = 0;
            if (!cart_kind || addr < 16'hA000 || addr > 16'hBFFF)
                return 1'b0;
            if (ram_key != cbc_pkg::RAM_ENABLE_KEY || ram_code < 2'd2)
                return 1'b0;
            if (ram_code == cbc_pkg::RAM_SIZE_FOUR_BANKS && bank_mode)
                bank = int'(upper_bits);
            bank = bank % cbc_pkg::RAM_BANK_COUNT_DEFAULT;
            idx = bank * cbc_pkg::RAM_BANK_BYTES + int'(addr[12:0]);
            return 1'b1;
        endfunction

        function void note_access(logic [2:0] act, logic [15:0] addr, logic [7:0] data);
            bank_answer_t ans;
            int idx;
            int bank;
            int mask;
            ans.src = cbc_pkg::SRC_OPEN;
            ans.rom_addr = '0;
            ans.rdata = 8'hFF;
            mask = (2 << rom_code) - 1;
            case (act)
                cbc_pkg::ACT_ROM_READ:
                begin
                    if (addr < 16'h0100 && boot_overlay)
                    begin
                        ans.src = cbc_pkg::SRC_BOOT;
                        ans.rom_addr = 21'(addr);
                    end
                    else if (addr <= 16'h7FFF)
                    begin
                        ans.src = cbc_pkg::SRC_ROM;
                        if (!cart_kind)
                            ans.rom_addr = 21'(addr);
                        else
                        begin
                            if (addr <= 16'h3FFF)
                                bank = bank_mode ? (int'({upper_bits, 5'd0}) & mask) : 0;
                            else
                                bank = int'({upper_bits, low_bank}) & mask;
                            ans.rom_addr = 21'(bank * cbc_pkg::ROM_BANK_BYTES
                                               + int'(addr[13:0]));
                        end
                    end
                end
                cbc_pkg::ACT_CTRL_WRITE:
                begin
                    if (cart_kind && addr <= 16'h7FFF)
                    begin
                        if (addr <= 16'h1FFF)
                            ram_key = data[3:0];
                        else if (addr <= 16'h3FFF)
                            low_bank = (data[4:0] == 5'd0) ? 5'd1 : data[4:0];
                        else if (addr <= 16'h5FFF)
                            upper_bits = data[1:0];
                        else
                            bank_mode = data[0];
                    end
                    ans.src = cbc_pkg::SRC_WRITE;
                end
                cbc_pkg::ACT_RAM_READ:
                begin
                    if (ram_slot(addr, idx))
                    begin
                        ans.src = cbc_pkg::SRC_RAM;
                        ans.rdata = cart_ram[idx];
                    end
                end
                cbc_pkg::ACT_RAM_WRITE:
                begin
                    if (ram_slot(addr, idx))
                        cart_ram[idx] = data;
                    ans.src = cbc_pkg::SRC_WRITE;
                end
                cbc_pkg::ACT_BOOT_UNMAP:
                begin
                    if (data != 8'h00)
                        boot_overlay = 1'b0;
                    ans.src = cbc_pkg::SRC_WRITE;
                end
                default: ;
            endcase
            answers.push_back(ans);
        endfunction

        function void check_result(logic [2:0] src, logic [20:0] ra, logic [7:0] rd);
            bank_answer_t want;
            if (answers.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected transfer out: source %0d rom_address %h read_data %h",
                             src, ra, rd);
                return;
            end
            want = answers.pop_front();
            if (src !== want.src || ra !== want.rom_addr || rd !== want.rdata)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected source %0d rom_address %h read_data %h, got %0d %h %h",
                             want.src, want.rom_addr, want.rdata, src, ra, rd);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = 4'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  action = 3'd0;
    logic [15:0] bus_address = 16'd0;
    logic [7:0]  write_data = 8'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  source;
    logic [20:0] rom_address;
    logic [7:0]  read_data;

    cart_scoreboard sb;
    bit             no_gaps = 1'b0;
    int             hold_cycles = 0;
    int             quiet_cycles = 0;

    cartridge_bank_controller dut (.*);

    always #6 clk = ~clk;

    // watchdog: cycles with no transfer on either side; covers the ram clearing pass
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // result side: check, then pick next ready
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                sb.check_result(source, rom_address, read_data);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                out_ready <= 1'b0;
            end
            else if (no_gaps)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 99) >= 20);
        end
    end

    // leaves psel up so back-to-back writes go straight to the next setup cycle
    task automatic apb_write(input cbc_pkg::reg_index_t idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.set_reg(idx, value);
    endtask

    task automatic load_cart_setup(input logic kind, input logic [2:0] rom_sz,
                                   input logic [1:0] ram_sz, input logic boot);
        apb_write(cbc_pkg::REG_CART_KIND, {31'd0, kind});
        apb_write(cbc_pkg::REG_ROM_SIZE, {29'd0, rom_sz});
        apb_write(cbc_pkg::REG_RAM_SIZE, {30'd0, ram_sz});
        apb_write(cbc_pkg::REG_BOOT_START, {31'd0, boot});
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send_access(input logic [2:0] act, input logic [15:0] addr,
                               input logic [7:0] data);
        in_valid <= 1'b1;
        action <= act;
        bus_address <= addr;
        write_data <= data;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_access(act, addr, data);
    endtask

    task automatic send_random_access();
        logic [2:0]  act;
        logic [15:0] addr;
        logic [7:0]  data;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            act = cbc_pkg::ACT_ROM_READ;
        else if (pick < 50)
            act = cbc_pkg::ACT_CTRL_WRITE;
        else if (pick < 68)
            act = cbc_pkg::ACT_RAM_READ;
        else if (pick < 86)
            act = cbc_pkg::ACT_RAM_WRITE;
        else if (pick < 94)
            act = cbc_pkg::ACT_BOOT_UNMAP;
        else
            act = 3'($urandom_range(5, 7));
        pick = $urandom_range(0, 9);
        addr = 16'($urandom);
        data = 8'($urandom);
        case (act)
            cbc_pkg::ACT_ROM_READ:
            begin
                if (pick == 0)
                    addr = 16'($urandom_range(0, 255));
                else if (pick < 8)
                    addr = 16'($urandom_range(0, 16'h7FFF));
            end
            cbc_pkg::ACT_CTRL_WRITE:
            begin
                if (pick < 9)
                    addr = 16'($urandom_range(0, 16'h7FFF));
                // keep the ram enabled most of the time
                if (addr <= 16'h1FFF && $urandom_range(0, 1) == 1)
                    data[3:0] = cbc_pkg::RAM_ENABLE_KEY;
            end
            cbc_pkg::ACT_RAM_READ, cbc_pkg::ACT_RAM_WRITE:
            begin
                // a small hot window so reads find earlier writes
                if (pick < 4)
                    addr = 16'hA000 + 16'($urandom_range(0, 31));
                else if (pick < 8)
                    addr = 16'($urandom_range(16'hA000, 16'hBFFF));
            end
            cbc_pkg::ACT_BOOT_UNMAP:
            begin
                if (pick < 5)
                    data = 8'h00;
            end
            default: ;
        endcase
        send_access(act, addr, data);
    endtask

    task automatic run_directed();
        // boot overlay edges, then a zero unmap that must not clear it
        send_access(cbc_pkg::ACT_ROM_READ, 16'h0000, 8'h00);
        send_access(cbc_pkg::ACT_ROM_READ, 16'h00FF, 8'hFF);
        send_access(cbc_pkg::ACT_ROM_READ, 16'h0100, 8'h00);
        send_access(cbc_pkg::ACT_BOOT_UNMAP, 16'hFF50, 8'h00);
        send_access(cbc_pkg::ACT_ROM_READ, 16'h0000, 8'h00);
        send_access(cbc_pkg::ACT_BOOT_UNMAP, 16'hFF50, 8'hFF);
        send_access(cbc_pkg::ACT_ROM_READ, 16'h0000, 8'h00);
        // ram disabled, then enabled
        send_access(cbc_pkg::ACT_RAM_READ, 16'hA000, 8'h00);
        send_access(cbc_pkg::ACT_CTRL_WRITE, 16'h0000, 8'h0A);
        send_access(cbc_pkg::ACT_RAM_WRITE, 16'hA000, 8'h55);
        send_access(cbc_pkg::ACT_RAM_READ, 16'hA000, 8'h00);
        send_access(cbc_pkg::ACT_RAM_WRITE, 16'hBFFF, 8'hFF);
        // bank zero write turns into bank one
        send_access(cbc_pkg::ACT_CTRL_WRITE, 16'h2000, 8'h00);
        send_access(cbc_pkg::ACT_ROM_READ, 16'h4000, 8'h00);
        send_access(cbc_pkg::ACT_CTRL_WRITE, 16'h3FFF, 8'hFF);
        send_access(cbc_pkg::ACT_CTRL_WRITE, 16'h4000, 8'hFF);
        send_access(cbc_pkg::ACT_CTRL_WRITE, 16'h6000, 8'h01);
        send_access(cbc_pkg::ACT_ROM_READ, 16'h3FFF, 8'h00);
        send_access(cbc_pkg::ACT_ROM_READ, 16'h7FFF, 8'h00);
        send_access(cbc_pkg::ACT_RAM_READ, 16'hBFFF, 8'h00);
        // out of window writes and reads, unknown actions
        send_access(cbc_pkg::ACT_RAM_WRITE, 16'hC000, 8'hAA);
        send_access(cbc_pkg::ACT_ROM_READ, 16'hFFFF, 8'h00);
        send_access(cbc_pkg::ACT_CTRL_WRITE, 16'h8000, 8'hFF);
        send_access(3'd7, 16'hFFFF, 8'hFF);
        send_access(3'd5, 16'h0000, 8'h00);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.answers.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    initial
    begin
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        // register writes are taken while the ram is still being cleared
        load_cart_setup(1'b1, 3'd0, 2'd3, 1'b1);
        run_directed();
        drain_results();
        for (int ph = 1; ph <= 9; ph++)
        begin
            case (ph)
                1: load_cart_setup(1'b1, 3'd6, 2'd3, 1'b0);
                2: load_cart_setup(1'b1, 3'd7, 2'd3, 1'b1);
                3: load_cart_setup(1'b0, 3'd3, 2'd2, 1'b1);
                4: load_cart_setup(1'b1, 3'd2, 2'd1, 1'b0);
                5: load_cart_setup(1'b1, 3'd5, 2'd2, 1'b0);
                6: load_cart_setup(1'b0, 3'd0, 2'd0, 1'b0);
                7: load_cart_setup(1'b1, 3'd4, 2'd3, 1'b1);
                default: load_cart_setup(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                                         2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
            endcase
            no_gaps = (ph == 1);
            // long receiver hold-off so the pipeline backs up into in_ready
            if (ph == 2)
                hold_cycles = 80;
            for (int n = 0; n < 100; n++)
            begin
                while (!no_gaps && $urandom_range(0, 99) < 20)
                begin
                    in_valid <= 1'b0;
                    @(posedge clk);
                end
                send_random_access();
            end
            drain_results();
        end
        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.answers.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/cbc_pkg.sv
rtl/cbc_cfg.sv
rtl/cbc_mapper.sv
rtl/cbc_ram.sv
rtl/cartridge_bank_controller.sv
dv/tb_top.sv
